@@ src/cascaded_angle_speed_pid_sweep_top_defines.svh @@
`ifndef CASCADED_ANGLE_SPEED_PID_SWEEP_TOP_DEFINES_SVH
`define CASCADED_ANGLE_SPEED_PID_SWEEP_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CASP_AST(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CASP_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/caspid_pkg.sv @@
package caspid_pkg;

	localparam int GAIN_W    = 16;
	localparam int RAW_W     = 13;
	localparam int SPD_W     = 16;
	localparam int DRV_W     = 16;
	localparam int AERR_W    = 19;
	localparam int AINT_W    = 18;
	localparam int SERR_W    = 27;
	localparam int SINT_W    = 24;
	localparam int OP_W      = 28;
	localparam int PROD_W    = GAIN_W + 1 + OP_W;
	localparam int ACC_W     = 48;
	localparam int ANG_W     = 21;
	localparam int CFG_IDX_W = 3;
	localparam int MAX_MOTORS = 2;

	// angles in 1/1024 degree
	localparam logic signed [ANG_W-1:0] HALF_TURN  = 21'sd184320;
	localparam logic signed [ANG_W-1:0] FULL_TURN  = 21'sd368640;
	localparam logic signed [ANG_W-1:0] TARGET_MAG = 21'sd30720;

	localparam logic signed [ACC_W-1:0] OUTER_IMAX = 48'sd102400;
	localparam logic signed [ACC_W-1:0] OUTER_OMAX = 48'sd83886080;
	localparam logic signed [ACC_W-1:0] INNER_IMAX = 48'sd8192000;
	localparam logic signed [ACC_W-1:0] INNER_OMAX = 48'sd6553600000;

	localparam logic [CFG_IDX_W-1:0] REG_KP_OUTER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_OUTER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD_OUTER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KP_INNER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KI_INNER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KD_INNER = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_A   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_B   = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_ERR,
		ST_KI_O,
		ST_KP_O,
		ST_KD_O,
		ST_OSUM,
		ST_OSPD,
		ST_KI_I,
		ST_KP_I,
		ST_KD_I,
		ST_ISUM,
		ST_IOUT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [GAIN_W-1:0]      gain;
		logic signed [OP_W-1:0] opnd;
	} mul_req_t;

endpackage

@@ src/caspid_mul.sv @@
module caspid_mul (
	input  logic                                      clk,
	input  caspid_pkg::mul_req_t                      req,
	output logic signed [caspid_pkg::PROD_W-1:0]      prod_s1
);
	import caspid_pkg::*;

	logic signed [PROD_W-1:0] gain_x;
	logic signed [PROD_W-1:0] opnd_x;

	// gain is unsigned Q8.8, operand is a signed error term
	assign gain_x = PROD_W'($signed({1'b0, req.gain}));
	assign opnd_x = PROD_W'(req.opnd);

	always_ff @(posedge clk) begin
		prod_s1 <= gain_x * opnd_x;
	end

endmodule

@@ src/cascaded_angle_speed_pid_sweep_top.sv @@
// Two-motor cascaded angle/speed PID. Each request is one control tick with both encoder
// counts and speeds; it returns one result with both drive values and the target sign.
// All products go through one registered 17x28 multiplier, six per motor, under a small
// sequencer that handles one request at a time: in_ready is low from acceptance until the
// sequencer returns to idle, as the result is loaded into the output register.
// A new request may be taken while a finished result still waits on out_ready. The user
// must write gains and zero positions through the cfg port only while the block is idle;
// the block itself does not enforce this.
`include "cascaded_angle_speed_pid_sweep_top_defines.svh"

module cascaded_angle_speed_pid_sweep_top #(
	parameter int SWITCH_TICKS = 200,
	parameter int NUM_MOTORS   = 2
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic [caspid_pkg::CFG_IDX_W-1:0]           cfg_idx,
	input  logic [caspid_pkg::GAIN_W-1:0]              cfg_wdata,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [caspid_pkg::RAW_W-1:0]               raw_angle_a,
	input  logic signed [caspid_pkg::SPD_W-1:0]        speed_a,
	input  logic [caspid_pkg::RAW_W-1:0]               raw_angle_b,
	input  logic signed [caspid_pkg::SPD_W-1:0]        speed_b,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic signed [caspid_pkg::DRV_W-1:0]        drive_a,
	output logic signed [caspid_pkg::DRV_W-1:0]        drive_b,
	output logic                                       target_positive
);
	import caspid_pkg::*;

	localparam logic [7:0] SW_TICKS = 8'(SWITCH_TICKS);
	localparam logic       LAST_M   = 1'(NUM_MOTORS - 1);

	function automatic logic signed [AERR_W-1:0] wrap_ang(input logic signed [ANG_W-1:0] e);
		logic signed [ANG_W-1:0] r;
		r = e;
		if (e > HALF_TURN)
			r = e - FULL_TURN;
		else if (e < -HALF_TURN)
			r = e + FULL_TURN;
		return r[AERR_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] clamp48(input logic signed [ACC_W-1:0] v,
			input logic signed [ACC_W-1:0] lim);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > lim)
			r = lim;
		else if (v < -lim)
			r = -lim;
		return r;
	endfunction

	// config
	logic [GAIN_W-1:0] kp_o_q, ki_o_q, kd_o_q, kp_i_q, ki_i_q, kd_i_q;
	logic [RAW_W-1:0]  zero_a_q, zero_b_q;

	// control
	state_t state_q, state_d;
	logic   motor_q;
	logic [7:0] tick_q;
	logic   sign_q;
	logic   out_valid_q;
	logic signed [AERR_W-1:0] prev_aerr_q [MAX_MOTORS];
	logic signed [AINT_W-1:0] aint_q      [MAX_MOTORS];
	logic signed [SERR_W-1:0] prev_serr_q [MAX_MOTORS];
	logic signed [SINT_W-1:0] sint_q      [MAX_MOTORS];

	// payload
	logic [RAW_W-1:0]         raw_a_q, raw_b_q;
	logic signed [SPD_W-1:0]  spd_a_q, spd_b_q;
	logic signed [AERR_W-1:0] cur_q, aerr_q;
	logic signed [SERR_W-1:0] serr_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DRV_W-1:0]  drv_q [MAX_MOTORS];
	logic signed [DRV_W-1:0]  drive_a_q, drive_b_q;
	logic                     tpos_q;

	mul_req_t                 mreq;
	logic signed [PROD_W-1:0] prod_s1;

	logic accept, load_out;

	logic [RAW_W-1:0]         raw_m, zero_m;
	logic signed [SPD_W-1:0]  spd_m;
	logic signed [RAW_W:0]    diff;
	logic signed [19:0]       d20, cur_raw;
	logic signed [ANG_W-1:0]  tgt, err_raw;
	logic signed [ACC_W-1:0]  prod48, ospd, icl, imag, iq, idrv;
	logic signed [AINT_W-1:0] aint_d;
	logic signed [SINT_W-1:0] sint_d;
	logic signed [SERR_W-1:0] serr_d;
	logic signed [DRV_W-1:0]  drv_d;
	logic [7:0]               tick_n;

	caspid_mul u_mul (
		.clk     (clk),
		.req     (mreq),
		.prod_s1 (prod_s1)
	);

	assign accept   = in_valid & in_ready;
	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// per-motor angle and error math
	always_comb begin
		raw_m   = motor_q ? raw_b_q : raw_a_q;
		zero_m  = motor_q ? zero_b_q : zero_a_q;
		spd_m   = motor_q ? spd_b_q : spd_a_q;
		diff    = $signed({1'b0, raw_m}) - $signed({1'b0, zero_m});
		d20     = 20'(diff);
		cur_raw = (d20 <<< 5) + (d20 <<< 3) + (d20 <<< 2) + d20; // count * 45
		tgt     = sign_q ? TARGET_MAG : -TARGET_MAG;
		err_raw = tgt - ANG_W'(cur_q);
		prod48  = ACC_W'(prod_s1);
		aint_d  = AINT_W'(clamp48(ACC_W'(aint_q[motor_q]) + (prod48 >>> 8), OUTER_IMAX));
		sint_d  = SINT_W'(clamp48(ACC_W'(sint_q[motor_q]) + (prod48 >>> 8), INNER_IMAX));
		ospd    = clamp48(acc_q, OUTER_OMAX) >>> 8;
		serr_d  = SERR_W'(ospd - (ACC_W'(spd_m) <<< 10));
		icl     = clamp48(acc_q, INNER_OMAX);
		imag    = icl[ACC_W-1] ? -icl : icl;
		iq      = imag >>> 18;
		idrv    = icl[ACC_W-1] ? -iq : iq;
		drv_d   = DRV_W'(idrv);
		tick_n  = tick_q + 8'd1;
	end

	// sequencer: next state, ready and multiplier operands
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mreq.gain = '0;
		mreq.opnd = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = ST_ANGLE;
			end
			ST_ANGLE: state_d = ST_ERR;
			ST_ERR:   state_d = ST_KI_O;
			ST_KI_O: begin
				mreq.gain = ki_o_q;
				mreq.opnd = OP_W'(aerr_q);
				state_d   = ST_KP_O;
			end
			ST_KP_O: begin
				mreq.gain = kp_o_q;
				mreq.opnd = OP_W'(aerr_q);
				state_d   = ST_KD_O;
			end
			ST_KD_O: begin
				mreq.gain = kd_o_q;
				mreq.opnd = OP_W'(aerr_q) - OP_W'(prev_aerr_q[motor_q]);
				state_d   = ST_OSUM;
			end
			ST_OSUM: state_d = ST_OSPD;
			ST_OSPD: state_d = ST_KI_I;
			ST_KI_I: begin
				mreq.gain = ki_i_q;
				mreq.opnd = OP_W'(serr_q);
				state_d   = ST_KP_I;
			end
			ST_KP_I: begin
				mreq.gain = kp_i_q;
				mreq.opnd = OP_W'(serr_q);
				state_d   = ST_KD_I;
			end
			ST_KD_I: begin
				mreq.gain = kd_i_q;
				mreq.opnd = OP_W'(serr_q) - OP_W'(prev_serr_q[motor_q]);
				state_d   = ST_ISUM;
			end
			ST_ISUM: state_d = ST_IOUT;
			ST_IOUT: state_d = (motor_q == LAST_M) ? ST_FINISH : ST_ANGLE;
			ST_FINISH: begin
				if (!out_valid_q || out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_o_q   <= 16'd1024;
			ki_o_q   <= '0;
			kd_o_q   <= '0;
			kp_i_q   <= 16'd20480;
			ki_i_q   <= '0;
			kd_i_q   <= '0;
			zero_a_q <= '0;
			zero_b_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KP_OUTER: kp_o_q   <= cfg_wdata;
				REG_KI_OUTER: ki_o_q   <= cfg_wdata;
				REG_KD_OUTER: kd_o_q   <= cfg_wdata;
				REG_KP_INNER: kp_i_q   <= cfg_wdata;
				REG_KI_INNER: ki_i_q   <= cfg_wdata;
				REG_KD_INNER: kd_i_q   <= cfg_wdata;
				REG_ZERO_A:   zero_a_q <= cfg_wdata[RAW_W-1:0];
				REG_ZERO_B:   zero_b_q <= cfg_wdata[RAW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_q     <= 1'b0;
			tick_q      <= '0;
			sign_q      <= 1'b1;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_MOTORS; i++) begin
				prev_aerr_q[i] <= '0;
				aint_q[i]      <= '0;
				prev_serr_q[i] <= '0;
				sint_q[i]      <= '0;
			end
		end else begin
			if (accept) begin
				motor_q <= 1'b0;
				if (tick_n >= SW_TICKS) begin
					// target flips and every integrator restarts
					tick_q <= '0;
					sign_q <= ~sign_q;
					for (int i = 0; i < MAX_MOTORS; i++) begin
						aint_q[i] <= '0;
						sint_q[i] <= '0;
					end
				end else begin
					tick_q <= tick_n;
				end
			end
			case (state_q)
				ST_KP_O: aint_q[motor_q]      <= aint_d;
				ST_OSUM: prev_aerr_q[motor_q] <= aerr_q;
				ST_KP_I: sint_q[motor_q]      <= sint_d;
				ST_ISUM: prev_serr_q[motor_q] <= serr_q;
				ST_IOUT: begin
					if (motor_q != LAST_M)
						motor_q <= motor_q + 1'b1;
				end
				default: ;
			endcase
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_a_q <= raw_angle_a;
			spd_a_q <= speed_a;
			raw_b_q <= raw_angle_b;
			spd_b_q <= speed_b;
		end
		case (state_q)
			ST_ANGLE: cur_q  <= wrap_ang(ANG_W'(cur_raw));
			ST_ERR:   aerr_q <= wrap_ang(err_raw);
			// P product plus the freshly updated integrator
			ST_KD_O:  acc_q  <= prod48 + (ACC_W'(aint_q[motor_q]) <<< 8);
			ST_OSUM:  acc_q  <= acc_q + prod48;
			ST_OSPD:  serr_q <= serr_d;
			ST_KD_I:  acc_q  <= prod48 + (ACC_W'(sint_q[motor_q]) <<< 8);
			ST_ISUM:  acc_q  <= acc_q + prod48;
			ST_IOUT:  drv_q[motor_q] <= drv_d;
			default: ;
		endcase
		if (load_out) begin
			drive_a_q <= drv_q[0];
			drive_b_q <= (NUM_MOTORS > 1) ? drv_q[1] : '0;
			tpos_q    <= sign_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_a         = drive_a_q;
	assign drive_b         = drive_b_q;
	assign target_positive = tpos_q;

	`CASP_AST(a_aint_range, 1'b1, (aint_q[0] <= 18'sd102400) && (aint_q[0] >= -18'sd102400), "angle integrator out of range")
	`CASP_AST_NEXT(a_start, accept, (state_q == ST_ANGLE) && (motor_q == 1'b0), "request did not start at motor A")
	`CASP_AST_NEXT(a_no_extra, out_valid && out_ready && (state_q != ST_FINISH), !out_valid, "result repeated")
	`CASP_AST(a_drv_range, out_valid, (drive_a <= 16'sd25000) && (drive_a >= -16'sd25000), "drive_a beyond saturation")

endmodule

@@ verif/cascaded_angle_speed_pid_sweep_top_tb.sv @@
`timescale 1ns / 1ps

module cascaded_angle_speed_pid_sweep_top_tb;
	import caspid_pkg::*;

	localparam int SWEEP_TICKS = 200;
	localparam int MOTOR_COUNT = 2;
	localparam int IDLE_PCT = 19;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 6;
	localparam int TICKS_PER_PHASE = 300;

	// 1/1024 degree units and loop limits
	localparam longint DEG_HALF = 180 * 1024;
	localparam longint DEG_FULL = 360 * 1024;
	localparam longint AIM_MAG = 30 * 1024;
	localparam longint OUTER_ILIM = 100 * 1024;
	localparam longint OUTER_OLIM = 320 * (64'sd1 << 18);
	localparam longint INNER_ILIM = 8000 * 1024;
	localparam longint INNER_OLIM = 25000 * (64'sd1 << 18);

	typedef struct packed {
		logic signed [DRV_W-1:0] drv_a;
		logic signed [DRV_W-1:0] drv_b;
		logic                    tgt_pos;
	} tick_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [GAIN_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [RAW_W-1:0] raw_angle_a = '0;
	logic signed [SPD_W-1:0] speed_a = '0;
	logic [RAW_W-1:0] raw_angle_b = '0;
	logic signed [SPD_W-1:0] speed_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DRV_W-1:0] drive_a;
	logic signed [DRV_W-1:0] drive_b;
	logic target_positive;

	bit burst = 1'b0;
	int mismatch_count = 0;
	int stall_cycles = 0;
	tick_result_t expected_drives[$];
	tick_result_t head;

	// controller shadow: registers, sweep state and per-motor loop state
	logic [GAIN_W-1:0] reg_shadow [8] = '{16'd1024, 16'd0, 16'd0, 16'd20480,
		16'd0, 16'd0, 16'd0, 16'd0};
	int tick_phase = 0;
	bit aim_up = 1'b1;
	longint ang_prev [2] = '{0, 0};
	longint ang_acc [2] = '{0, 0};
	longint spd_prev [2] = '{0, 0};
	longint spd_acc [2] = '{0, 0};

	cascaded_angle_speed_pid_sweep_top #(
		.SWITCH_TICKS(SWEEP_TICKS),
		.NUM_MOTORS(MOTOR_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_angle_a(raw_angle_a),
		.speed_a(speed_a),
		.raw_angle_b(raw_angle_b),
		.speed_b(speed_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_a(drive_a),
		.drive_b(drive_b),
		.target_positive(target_positive)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint wrap_deg(input longint e);
		if (e > DEG_HALF) return e - DEG_FULL;
		if (e < -DEG_HALF) return e + DEG_FULL;
		return e;
	endfunction

	function automatic longint sat(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint motor_drive(input int m, input logic [RAW_W-1:0] raw,
			input logic [RAW_W-1:0] zero, input logic signed [SPD_W-1:0] spd);
		longint kpo = longint'(reg_shadow[REG_KP_OUTER]);
		longint kio = longint'(reg_shadow[REG_KI_OUTER]);
		longint kdo = longint'(reg_shadow[REG_KD_OUTER]);
		longint kpi = longint'(reg_shadow[REG_KP_INNER]);
		longint kii = longint'(reg_shadow[REG_KI_INNER]);
		longint kdi = longint'(reg_shadow[REG_KD_INNER]);
		longint cur, aerr, acc, tspd, serr;
		cur = wrap_deg(longint'(raw) * 45 - longint'(zero) * 45);
		aerr = wrap_deg((aim_up ? AIM_MAG : -AIM_MAG) - cur);
		ang_acc[m] = sat(ang_acc[m] + ((kio * aerr) >>> 8), OUTER_ILIM);
		acc = kpo * aerr + ang_acc[m] * 256 + kdo * (aerr - ang_prev[m]);
		ang_prev[m] = aerr;
		tspd = sat(acc, OUTER_OLIM) >>> 8;
		serr = tspd - longint'(spd) * 1024;
		spd_acc[m] = sat(spd_acc[m] + ((kii * serr) >>> 8), INNER_ILIM);
		acc = kpi * serr + spd_acc[m] * 256 + kdi * (serr - spd_prev[m]);
		spd_prev[m] = serr;
		acc = sat(acc, INNER_OLIM);
		// truncate toward zero
		return (acc >= 0) ? (acc >>> 18) : -((-acc) >>> 18);
	endfunction

	function automatic tick_result_t predict_tick(input logic [RAW_W-1:0] ra,
			input logic signed [SPD_W-1:0] sa, input logic [RAW_W-1:0] rb,
			input logic signed [SPD_W-1:0] sb);
		tick_result_t r;
		tick_phase = (tick_phase + 1) % 256;
		if (tick_phase >= SWEEP_TICKS) begin
			tick_phase = 0;
			aim_up = !aim_up;
			for (int m = 0; m < 2; m++) begin
				ang_acc[m] = 0;
				spd_acc[m] = 0;
			end
		end
		r.drv_a = DRV_W'(motor_drive(0, ra, reg_shadow[REG_ZERO_A][RAW_W-1:0], sa));
		r.drv_b = '0;
		if (MOTOR_COUNT > 1)
			r.drv_b = DRV_W'(motor_drive(1, rb, reg_shadow[REG_ZERO_B][RAW_W-1:0], sb));
		r.tgt_pos = aim_up;
		return r;
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3, 4: return GAIN_W'($urandom_range(0, 512));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	function automatic int near(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic send_tick(input logic [RAW_W-1:0] ra, input logic signed [SPD_W-1:0] sa,
			input logic [RAW_W-1:0] rb, input logic signed [SPD_W-1:0] sb);
		if (!burst && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_angle_a <= ra;
		speed_a <= sa;
		raw_angle_b <= rb;
		speed_b <= sb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_drives.push_back(predict_tick(ra, sa, rb, sb));
	endtask

	task automatic drain_ticks();
		in_valid <= 1'b0;
		while (expected_drives.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [GAIN_W-1:0] kpo, kio, kdo, kpi, kii, kdi,
			za, zb);
		logic [GAIN_W-1:0] vals [8];
		logic [CFG_IDX_W-1:0] idx;
		vals[REG_KP_OUTER] = kpo;
		vals[REG_KI_OUTER] = kio;
		vals[REG_KD_OUTER] = kdo;
		vals[REG_KP_INNER] = kpi;
		vals[REG_KI_INNER] = kii;
		vals[REG_KD_INNER] = kdi;
		vals[REG_ZERO_A] = za;
		vals[REG_ZERO_B] = zb;
		drain_ticks();
		for (int i = 0; i < 8; i++) begin
			idx = CFG_IDX_W'(i);
			cfg_we <= 1'b1;
			cfg_idx <= idx;
			cfg_wdata <= vals[idx];
			@(posedge clk);
			// zero positions keep only the encoder width
			if (idx == REG_ZERO_A || idx == REG_ZERO_B)
				reg_shadow[idx] = vals[idx] & {{(GAIN_W-RAW_W){1'b0}}, {RAW_W{1'b1}}};
			else
				reg_shadow[idx] = vals[idx];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_field_extremes();
		send_tick(13'd0, 16'sd0, 13'd0, 16'sd0);
		send_tick(13'd8191, 16'sd32767, 13'd8191, -16'sd32768);
		send_tick(13'd8191, -16'sd32768, 13'd0, 16'sd32767);
		// exactly +180 kept on A, just past it wraps on B
		send_tick(13'd4096, 16'sd1, 13'd4097, -16'sd1);
		send_tick(13'd4095, -16'sd1, 13'd1, 16'sd0);
		send_tick(13'd683, 16'sd30, 13'd7509, -16'sd30);
	endtask

	task automatic test_angle_wrap();
		// upper bits of both zero writes must be dropped: zero A 8191, zero B 4096
		load_settings(16'd1024, 16'd256, 16'd512, 16'd256, 16'd128, 16'd64,
			16'hFFFF, 16'hF000);
		send_tick(13'd0, 16'sd0, 13'd0, 16'sd0);
		send_tick(13'd4095, 16'sd100, 13'd8191, -16'sd100);
		send_tick(13'd8191, -16'sd5, 13'd4096, 16'sd5);
		send_tick(13'd4094, 16'sd0, 13'd1, 16'sd0);
		send_tick(13'd3, 16'sd0, 13'd12, 16'sd0);
	endtask

	task automatic test_gain_extremes();
		load_settings('1, '1, '1, '1, '1, '1, 16'd0, 16'd0);
		send_tick(13'd683, 16'sd0, 13'd7509, 16'sd0);
		send_tick(13'd100, 16'sd32767, 13'd8000, -16'sd32768);
		send_tick(13'd0, 16'sd0, 13'd0, 16'sd0);
		send_tick(13'd4096, -16'sd32768, 13'd4096, 16'sd32767);
		load_settings('0, '0, '0, '0, '0, '0, 16'h1FFF, 16'd0);
		send_tick(13'd1234, 16'sd500, 13'd4321, -16'sd500);
		send_tick(13'd8191, -16'sd32768, 13'd0, 16'sd32767);
		// saturated outer loop into a unity inner gain: target speed shows through
		load_settings('1, '1, '1, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0);
		send_tick(13'd4000, 16'sd0, 13'd6000, 16'sd0);
		send_tick(13'd683, 16'sd300, 13'd7509, -16'sd300);
		send_tick(13'd0, -16'sd10, 13'd2000, 16'sd10);
	endtask

	task automatic test_random_sweep();
		logic [RAW_W-1:0] ra, rb;
		logic signed [SPD_W-1:0] sa, sb;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
				rand_gain(), GAIN_W'($urandom), GAIN_W'($urandom));
			burst = (p == 2);
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 20) begin
					ra = RAW_W'($urandom);
					sa = SPD_W'($urandom);
					rb = RAW_W'($urandom);
					sb = SPD_W'($urandom);
				end else begin
					// angles within 900 counts of the zero position, spanning both sweep targets, plausible speeds
					ra = RAW_W'(int'(reg_shadow[REG_ZERO_A]) + near(900));
					rb = RAW_W'(int'(reg_shadow[REG_ZERO_B]) + near(900));
					sa = SPD_W'(near(600));
					sb = SPD_W'(near(600));
				end
				send_tick(ra, sa, rb, sb);
			end
			burst = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		out_ready <= burst || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_drives.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				head = expected_drives.pop_front();
				if (drive_a !== head.drv_a)
					report_mismatch($sformatf("drive_a got %0d want %0d", drive_a, head.drv_a));
				if (drive_b !== head.drv_b)
					report_mismatch($sformatf("drive_b got %0d want %0d", drive_b, head.drv_b));
				if (target_positive !== head.tgt_pos)
					report_mismatch($sformatf("target_positive got %b want %b",
						target_positive, head.tgt_pos));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_angle_wrap();
		test_gain_extremes();
		test_random_sweep();
		drain_ticks();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/caspid_pkg.sv
src/caspid_mul.sv
src/cascaded_angle_speed_pid_sweep_top.sv
verif/cascaded_angle_speed_pid_sweep_top_tb.sv
